// ===== hdl/soc2d_pkg.sv =====
// shared types, constants, microprogram and helper functions for the overscroll clamp
`default_nettype none

package soc2d_pkg;

  // field widths
  localparam int DATA_W  = 32;
  localparam int EXC_W   = DATA_W + 1;
  localparam int LIM_W   = 31;
  localparam int GAIN_W  = 24;
  localparam int TS_W    = 16;
  localparam int DT_W    = 13;
  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = 57;
  localparam int WIDE_W  = PROD_W + 1;
  localparam int MAG_W   = 7;
  localparam int SQ_W    = 2 * MAG_W + 1;
  localparam int STEP_W  = 4;
  localparam int CFG_A_W = 3;

  // numeric constants
  localparam logic [DT_W-1:0]          DT_MAX      = 13'd5243;
  localparam logic signed [DATA_W-1:0] SNAP_EPS    = 32'sd1311;
  localparam logic [MAG_W-1:0]         CAPTURE_CAP = 7'd7;
  localparam logic [SQ_W-1:0]          CAPTURE_MIN = 15'd43;
  localparam logic [MAG_W-1:0]         ACTIVE_CAP  = 7'd66;
  localparam logic [SQ_W-1:0]          ACTIVE_MIN  = 15'd4295;
  localparam logic signed [WIDE_W-1:0] RND_HALF    = 58'sd32768;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_SNAP = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PASS = 4'd11;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd11;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_BOUNDS_VALID = 3'd0,
    REG_MIN_X        = 3'd1,
    REG_MAX_X        = 3'd2,
    REG_MIN_Y        = 3'd3,
    REG_MAX_Y        = 3'd4,
    REG_LIMIT        = 3'd5,
    REG_SPRING       = 3'd6,
    REG_DAMPING      = 3'd7
  } cfg_reg_t;

  // multiplier operand select
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KO,
    MUL_CV,
    MUL_AD,
    MUL_VD
  } mul_sel_t;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_RND
  } acc_op_t;

  // datapath operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLAMP,
    OP_CAPTURE,
    OP_VUPD,
    OP_OUPD,
    OP_SNAP,
    OP_OUT,
    OP_PASS
  } dp_op_t;

  // jump condition
  typedef enum logic [1:0] {
    C_NEVER,
    C_NOVALID,
    C_DTZERO
  } cond_t;

  typedef struct packed {
    mul_sel_t          mul;
    acc_op_t           acc;
    dp_op_t            op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] s);
    ucode_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, op: OP_NONE, cond: C_NEVER,
          target: '0, last: 1'b0};
    case (s)
      4'd0: begin
        w.op = OP_CLAMP; w.cond = C_NOVALID; w.target = STEP_PASS;
      end
      4'd1: begin
        w.op = OP_CAPTURE; w.cond = C_DTZERO; w.target = STEP_SNAP;
      end
      4'd2: w.mul = MUL_KO;
      4'd3: begin
        w.mul = MUL_CV; w.acc = ACC_LOAD;
      end
      4'd4: w.acc = ACC_RND;
      4'd5: w.mul = MUL_AD;
      4'd6: w.op = OP_VUPD;
      4'd7: w.mul = MUL_VD;
      4'd8: w.op = OP_OUPD;
      4'd9: w.op = OP_SNAP;
      4'd10: begin
        w.op = OP_OUT; w.last = 1'b1;
      end
      4'd11: begin
        w.op = OP_PASS; w.last = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 58'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -58'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // magnitude limited to cap
  function automatic logic [MAG_W-1:0] cap_mag(input logic signed [EXC_W-1:0] x,
                                               input logic [MAG_W-1:0] cap);
    logic signed [EXC_W-1:0] cs;
    logic signed [EXC_W-1:0] m;
    logic [MAG_W-1:0]        r;
    cs = $signed({{(EXC_W-MAG_W){1'b0}}, cap});
    m  = (x < 0) ? -x : x;
    if (x >= cs || x <= -cs) begin
      r = cap;
    end else begin
      r = m[MAG_W-1:0];
    end
    return r;
  endfunction

  // sum of squares of two capped magnitudes
  function automatic logic [SQ_W-1:0] cap_sq(input logic signed [EXC_W-1:0] a,
                                             input logic signed [EXC_W-1:0] b,
                                             input logic [MAG_W-1:0] cap);
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    ma = cap_mag(a, cap);
    mb = cap_mag(b, cap);
    return SQ_W'(ma * ma) + SQ_W'(mb * mb);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/soc2d_if.sv =====
// valid/ready channel interfaces for input items and results
`default_nettype none

interface soc2d_in_if import soc2d_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] desired_x;
  logic signed [DATA_W-1:0] desired_y;
  logic [TS_W-1:0]          time_step;

  modport source (output valid, desired_x, desired_y, time_step, input ready);
  modport sink (input valid, desired_x, desired_y, time_step, output ready);
endinterface

interface soc2d_out_if import soc2d_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic                     active;

  modport source (output valid, pos_x, pos_y, active, input ready);
  modport sink (input valid, pos_x, pos_y, active, output ready);
endinterface

`default_nettype wire

// ===== hdl/soc2d_axis.sv =====
// one axis of the datapath: clamp, capture, spring multiplier and state
`default_nettype none

module soc2d_axis import soc2d_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ucode_t                   uw,
  input  wire logic                     exec,
  input  wire logic                     capture,
  input  wire logic signed [DATA_W-1:0] d,
  input  wire logic signed [DATA_W-1:0] lo,
  input  wire logic signed [DATA_W-1:0] hi,
  input  wire logic [LIM_W-1:0]         limit,
  input  wire logic [GAIN_W-1:0]        gain_k,
  input  wire logic [GAIN_W-1:0]        gain_c,
  input  wire logic [DT_W-1:0]          dt,
  output logic signed [DATA_W-1:0]      c_out,
  output logic signed [EXC_W-1:0]       e_out,
  output logic signed [DATA_W-1:0]      o_out,
  output logic signed [DATA_W-1:0]      v_out
);

  logic signed [DATA_W-1:0] c_r, c_nxt;
  logic signed [EXC_W-1:0]  e_r, e_nxt;
  logic signed [DATA_W-1:0] o_r, o_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  logic signed [DATA_W-1:0]  clamped;
  logic signed [EXC_W-1:0]   sel_o;
  logic signed [EXC_W-1:0]   lim_p;
  logic signed [EXC_W-1:0]   lim_n;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
  logic signed [WIDE_W-1:0]  rnd_sum;
  logic signed [WIDE_W-1:0]  upd_sum;
  logic                      in_snap;

  // box clamp, lower bound tested first
  always_comb begin
    if (d < lo) begin
      clamped = lo;
    end else if (d > hi) begin
      clamped = hi;
    end else begin
      clamped = d;
    end
  end

  // capture source and limit window
  assign sel_o = capture ? e_r : EXC_W'(o_r);
  assign lim_p = $signed({2'b00, limit});
  assign lim_n = -lim_p;

  // shared multiplier operands
  always_comb begin
    case (uw.mul)
      MUL_KO: begin
        mul_a = MUL_A_W'(o_r);
        mul_b = $signed({1'b0, gain_k});
      end
      MUL_CV: begin
        mul_a = MUL_A_W'(v_r);
        mul_b = $signed({1'b0, gain_c});
      end
      MUL_AD: begin
        mul_a = acc_r[MUL_A_W-1:0];
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt});
      end
      MUL_VD: begin
        mul_a = MUL_A_W'(v_r);
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // half-up rounded acceleration: -(k*o) - c*v
  assign rnd_sum = RND_HALF - WIDE_W'(acc_r) - WIDE_W'(prod_r);

  // state update: state + round(prod / 2^16)
  always_comb begin
    if (uw.op == OP_OUPD) begin
      upd_sum = ((WIDE_W'(prod_r) + RND_HALF) >>> 16) + WIDE_W'(o_r);
    end else begin
      upd_sum = ((WIDE_W'(prod_r) + RND_HALF) >>> 16) + WIDE_W'(v_r);
    end
  end

  assign in_snap = (o_r > -SNAP_EPS) && (o_r < SNAP_EPS) &&
                   (v_r > -SNAP_EPS) && (v_r < SNAP_EPS);

  // next values per control word
  always_comb begin
    c_nxt    = c_r;
    e_nxt    = e_r;
    o_nxt    = o_r;
    v_nxt    = v_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    if (exec) begin
      if (uw.mul != MUL_NONE) begin
        prod_nxt = mul_p[PROD_W-1:0];
      end
      case (uw.acc)
        ACC_LOAD: acc_nxt = prod_r;
        ACC_RND:  acc_nxt = PROD_W'(rnd_sum >>> 16);
        default:  acc_nxt = acc_r;
      endcase
      case (uw.op)
        OP_CLAMP: begin
          c_nxt = clamped;
          e_nxt = EXC_W'(d) - EXC_W'(clamped);
        end
        OP_CAPTURE: begin
          if (sel_o > lim_p) begin
            o_nxt = lim_p[DATA_W-1:0];
          end else if (sel_o < lim_n) begin
            o_nxt = lim_n[DATA_W-1:0];
          end else begin
            o_nxt = sel_o[DATA_W-1:0];
          end
        end
        OP_VUPD: v_nxt = sat32(upd_sum);
        OP_OUPD: o_nxt = sat32(upd_sum);
        OP_SNAP: begin
          if (in_snap) begin
            o_nxt = '0;
            v_nxt = '0;
          end
        end
        OP_PASS: begin
          o_nxt = '0;
          v_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // spring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_r <= '0;
      v_r <= '0;
    end else begin
      o_r <= o_nxt;
      v_r <= v_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    e_r    <= e_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign c_out = c_r;
  assign e_out = e_r;
  assign o_out = o_r;
  assign v_out = v_r;

endmodule

`default_nettype wire

// ===== hdl/spring_overscroll_clamp_2d.sv =====
// top level: config registers, microprogram sequencer, two axis lanes, result register
`default_nettype none

// Rubber-band clamp of a 2-D Q16.16 position. Each input beat is clamped into the
// configured box; a significant excess becomes the overscroll, limited to
// +/- overscroll_limit and pulled back by a damped spring (semi-implicit Euler,
// dt capped at 0.08 s). The result beat carries the clamped position plus the
// overscroll and an active flag. A microprogram of twelve steps drives both axes
// in lockstep, each axis with one shared multiplier that does four dependent
// multiplies (k*o, c*v, a*dt, v*dt). A zero time_step jumps to the snap step and
// a clear bounds_valid to the pass-through step, which sends the input on
// unchanged. The block is busy from acceptance to the next ready; a result beat
// not yet taken holds the last step and adds its wait. Configuration writes go
// to cfg_addr 0..7 in register order and take effect at once.

module spring_overscroll_clamp_2d import soc2d_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0]  cfg_wdata,
  soc2d_in_if.sink                in_ch,
  soc2d_out_if.source             out_ch
);

  // configuration registers
  logic                     bounds_valid_r;
  logic signed [DATA_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [LIM_W-1:0]         limit_r;
  logic [GAIN_W-1:0]        spring_r, damping_r;

  // item registers
  logic signed [DATA_W-1:0] d_x_r, d_y_r;
  logic [DT_W-1:0]          dt_r;

  // sequencer
  logic               busy_r, busy_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  ucode_t             uw;
  logic               accept;
  logic               stall;
  logic               exec;
  logic               jump;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [DATA_W-1:0] pos_y_r, pos_y_nxt;
  logic                     active_r, active_nxt;

  // lane outputs
  logic signed [DATA_W-1:0] c_x, c_y, o_x, o_y, v_x, v_y;
  logic signed [EXC_W-1:0]  e_x, e_y;
  logic                     capture;
  logic                     active_now;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_valid_r <= 1'b0;
      min_x_r        <= '0;
      max_x_r        <= '0;
      min_y_r        <= '0;
      max_y_r        <= '0;
      limit_r        <= '0;
      spring_r       <= '0;
      damping_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BOUNDS_VALID: bounds_valid_r <= cfg_wdata[0];
        REG_MIN_X:        min_x_r        <= cfg_wdata;
        REG_MAX_X:        max_x_r        <= cfg_wdata;
        REG_MIN_Y:        min_y_r        <= cfg_wdata;
        REG_MAX_Y:        max_y_r        <= cfg_wdata;
        REG_LIMIT:        limit_r        <= cfg_wdata[LIM_W-1:0];
        REG_SPRING:       spring_r       <= cfg_wdata[GAIN_W-1:0];
        REG_DAMPING:      damping_r      <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // control word fetch and handshake
  assign uw          = ucode_rom(step_r);
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign stall       = busy_r && (uw.op == OP_OUT || uw.op == OP_PASS) &&
                       out_valid_r && !out_ch.ready;
  assign exec        = busy_r && !stall;
  assign jump        = (uw.cond == C_NOVALID && !bounds_valid_r) ||
                       (uw.cond == C_DTZERO && dt_r == '0);

  // step counter
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (exec) begin
      if (uw.last) begin
        busy_nxt = 1'b0;
      end
      step_nxt = jump ? uw.target : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // input beat capture, time step capped at 0.08 s
  always_ff @(posedge clk) begin
    if (accept) begin
      d_x_r <= in_ch.desired_x;
      d_y_r <= in_ch.desired_y;
      dt_r  <= (in_ch.time_step > TS_W'(DT_MAX)) ? DT_MAX : in_ch.time_step[DT_W-1:0];
    end
  end

  // capture when the combined excess of both axes is significant
  assign capture = cap_sq(e_x, e_y, CAPTURE_CAP) >= CAPTURE_MIN;

  soc2d_axis u_axis_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .uw      (uw),
    .exec    (exec),
    .capture (capture),
    .d       (d_x_r),
    .lo      (min_x_r),
    .hi      (max_x_r),
    .limit   (limit_r),
    .gain_k  (spring_r),
    .gain_c  (damping_r),
    .dt      (dt_r),
    .c_out   (c_x),
    .e_out   (e_x),
    .o_out   (o_x),
    .v_out   (v_x)
  );

  soc2d_axis u_axis_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .uw      (uw),
    .exec    (exec),
    .capture (capture),
    .d       (d_y_r),
    .lo      (min_y_r),
    .hi      (max_y_r),
    .limit   (limit_r),
    .gain_k  (spring_r),
    .gain_c  (damping_r),
    .dt      (dt_r),
    .c_out   (c_y),
    .e_out   (e_y),
    .o_out   (o_y),
    .v_out   (v_y)
  );

  // spring still moving
  assign active_now = (cap_sq(EXC_W'(o_x), EXC_W'(o_y), ACTIVE_CAP) >= ACTIVE_MIN) ||
                      (cap_sq(EXC_W'(v_x), EXC_W'(v_y), ACTIVE_CAP) >= ACTIVE_MIN);

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    active_nxt    = active_r;
    if (exec && uw.op == OP_OUT) begin
      out_valid_nxt = 1'b1;
      pos_x_nxt     = sat32(WIDE_W'(c_x) + WIDE_W'(o_x));
      pos_y_nxt     = sat32(WIDE_W'(c_y) + WIDE_W'(o_y));
      active_nxt    = active_now;
    end else if (exec && uw.op == OP_PASS) begin
      out_valid_nxt = 1'b1;
      pos_x_nxt     = d_x_r;
      pos_y_nxt     = d_y_r;
      active_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r  <= pos_x_nxt;
    pos_y_r  <= pos_y_nxt;
    active_r <= active_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.pos_x  = pos_x_r;
  assign out_ch.pos_y  = pos_y_r;
  assign out_ch.active = active_r;

  // sequencer never leaves the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= LAST_STEP)
    else $error("step counter beyond program end");

  // finishing an item always presents a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && uw.last) |=> out_valid_r)
    else $error("item finished without a result");

  // pass-through clears the spring state
  a_pass_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && uw.op == OP_PASS) |=>
      (o_x == '0 && v_x == '0 && o_y == '0 && v_y == '0))
    else $error("spring state not cleared on pass-through");

  // after snapping the x axis does not stay inside the snap window unless it is zero
  a_snap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && uw.op == OP_SNAP) |=>
      (!(o_x > -SNAP_EPS && o_x < SNAP_EPS && v_x > -SNAP_EPS && v_x < SNAP_EPS) ||
       (o_x == '0 && v_x == '0)))
    else $error("x axis left inside snap window");

endmodule

`default_nettype wire
